/* design/pgw_pkg.sv */
`timescale 1ns / 1ps

package pgw_pkg;

	localparam int unsigned EntriesPerTable = 512;
	localparam int unsigned IdxW            = $clog2(EntriesPerTable);
	localparam int unsigned PageOffW        = 12;
	localparam int unsigned PaW             = 52;
	localparam int unsigned VaW             = 48;
	localparam int unsigned PageNumW        = PaW - PageOffW;
	localparam int unsigned WordIdxW        = 15;
	localparam int unsigned EntryW          = 64;
	localparam int unsigned DefStorePages   = 64;
	localparam int unsigned PresentBit      = 0;
	localparam int unsigned HugeBit         = 7;
	localparam int unsigned GibShift        = 30;
	localparam int unsigned MibShift        = 21;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_ABSENT  = 2'd1,
		STATUS_OUTSIDE = 2'd2,
		STATUS_WRITTEN = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SIZE_4K = 2'd0,
		SIZE_2M = 2'd1,
		SIZE_1G = 2'd2
	} page_size_t;

	typedef enum logic {
		FUNC_WRITE     = 1'b0,
		FUNC_TRANSLATE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		LVL_PT   = 2'd0,
		LVL_PD   = 2'd1,
		LVL_PDPT = 2'd2,
		LVL_PML4 = 2'd3
	} level_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_WALK = 2'd1,
		S_DONE = 2'd2
	} state_t;

	typedef struct packed {
		logic                func;
		logic [VaW-1:0]      vaddr;
		logic [WordIdxW-1:0] word_index;
		logic [EntryW-1:0]   write_data;
	} req_t;

	typedef struct packed {
		logic [1:0]     status;
		logic [PaW-1:0] paddr;
		logic [1:0]     page_size;
	} rsp_t;

endpackage

/* design/pgw_ram.sv */
`timescale 1ns / 1ps

module pgw_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/four_level_page_table_walk.sv */
`timescale 1ns / 1ps
// channel  | handshake                | payload
// req      | req_valid / req_stall    | req (func, vaddr, word_index, write_data)
// rsp      | rsp_valid / rsp_stall    | rsp (status, paddr, page_size)
// cfg      | cfg_valid / cfg_ready    | cfg_data (root_table_address)
//
// write, or translate with the root table outside the store: the result is registered in res_q,
// then in the output register; translate: one dependent store read per level walked (1 to 4),
// then the result goes through res_q into the output register; the table store is not cleared at reset
// one item is in work at a time; a finished result waits in the output register,
// so the next item is taken while rsp is stalled, and a walk holds its result until free

module four_level_page_table_walk
	import pgw_pkg::*;
#(
	parameter int unsigned STORE_PAGES = DefStorePages
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  req_t           req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output rsp_t           rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [PaW-1:0] cfg_data
);

	localparam int unsigned StoreWords = STORE_PAGES * EntriesPerTable;
	localparam int unsigned PgW        = $clog2(STORE_PAGES);
	localparam int unsigned AddrW      = PgW + IdxW;

	state_t              state_q, state_d;
	logic [PageNumW-1:0] root_page_q;
	logic [VaW-1:0]      va_q;
	logic [1:0]          level_q;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic              ram_we;
	logic [AddrW-1:0]  ram_waddr;
	logic              ram_re;
	logic [AddrW-1:0]  ram_raddr;
	logic [EntryW-1:0] ram_rdata;

	logic                req_fire;
	logic                out_free;
	logic                root_in;
	logic                wr_in;
	logic [PageNumW-1:0] ent_page;
	logic                walk_end;
	rsp_t                walk_res;
	logic                load_res;
	rsp_t                res_d;
	logic                level_load;
	logic [1:0]          level_d;

	function automatic logic [IdxW-1:0] idx_of(input logic [VaW-1:0] va, input logic [1:0] lvl);
		logic [IdxW-1:0] idx;
		case (lvl)
			LVL_PML4: idx = va[PageOffW+3*IdxW +: IdxW];
			LVL_PDPT: idx = va[PageOffW+2*IdxW +: IdxW];
			LVL_PD:   idx = va[PageOffW+IdxW +: IdxW];
			default:  idx = va[PageOffW +: IdxW];
		endcase
		return idx;
	endfunction

	pgw_ram #(
		.WIDTH(EntryW),
		.DEPTH(StoreWords)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.write_data),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign root_in   = root_page_q < PageNumW'(STORE_PAGES);
	assign wr_in     = 32'(req.word_index) < 32'(StoreWords);
	assign ent_page  = ram_rdata[PaW-1:PageOffW];
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// decide what the entry read back at the current level means
	always_comb begin
		walk_end = 1'b1;
		walk_res = '{status: STATUS_OK, paddr: '0, page_size: SIZE_4K};
		if (!ram_rdata[PresentBit]) begin
			walk_res.status = STATUS_ABSENT;
		end else if (level_q == LVL_PDPT && ram_rdata[HugeBit]) begin
			walk_res.paddr     = {ram_rdata[PaW-1:GibShift], va_q[GibShift-1:0]};
			walk_res.page_size = SIZE_1G;
		end else if (level_q == LVL_PD && ram_rdata[HugeBit]) begin
			walk_res.paddr     = {ram_rdata[PaW-1:MibShift], va_q[MibShift-1:0]};
			walk_res.page_size = SIZE_2M;
		end else if (level_q == LVL_PT) begin
			walk_res.paddr = {ent_page, va_q[PageOffW-1:0]};
		end else if (ent_page >= PageNumW'(STORE_PAGES)) begin
			walk_res.status = STATUS_OUTSIDE;
		end else begin
			walk_end = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					if (req.func == FUNC_TRANSLATE && root_in) begin
						state_d = S_WALK;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_WALK: begin
				if (walk_end) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_stall  = 1'b1;
		ram_we     = 1'b0;
		ram_waddr  = AddrW'(req.word_index);
		ram_re     = 1'b0;
		ram_raddr  = {root_page_q[PgW-1:0], idx_of(req.vaddr, LVL_PML4)};
		load_res   = 1'b0;
		res_d      = '{status: STATUS_WRITTEN, paddr: '0, page_size: SIZE_4K};
		level_load = 1'b0;
		level_d    = LVL_PML4;
		case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_fire) begin
					if (req.func == FUNC_WRITE) begin
						ram_we   = wr_in;
						load_res = 1'b1;
					end else if (root_in) begin
						ram_re     = 1'b1;
						level_load = 1'b1;
					end else begin
						load_res     = 1'b1;
						res_d.status = STATUS_OUTSIDE;
					end
				end
			end
			S_WALK: begin
				if (walk_end) begin
					load_res = 1'b1;
					res_d    = walk_res;
				end else begin
					// next level table entry
					ram_re     = 1'b1;
					ram_raddr  = {ent_page[PgW-1:0], idx_of(va_q, level_q - 2'd1)};
					level_load = 1'b1;
					level_d    = level_q - 2'd1;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_page_q <= '0;
			level_q     <= LVL_PML4;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				root_page_q <= cfg_data[PaW-1:PageOffW];
			end
			if (level_load) begin
				level_q <= level_d;
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			va_q <= req.vaddr;
		end
		if (load_res) begin
			res_q <= res_d;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_q <= res_q;
		end
	end

endmodule
